// File: src/pes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pes_pkg
// Shared types and constants of the peak envelope store.
// ----------------------------------------------------------------------------
package pes_pkg;

  localparam int BUCKET_DEPTH = 4096;
  localparam int MAX_CHANNELS = 8;
  localparam int ADDR_W       = $clog2(BUCKET_DEPTH);
  localparam int USED_W       = ADDR_W + 1;

  localparam int SAMPLE_W   = 16;
  localparam int RATE_W     = 19;
  localparam int BNS_W      = 34;
  localparam int CHC_W      = 4;
  localparam int TIME_W     = 64;
  localparam int FRAME_W    = 40;
  localparam int FRAME_HALF = FRAME_W / 2;
  localparam int NSEC_W     = 30;
  localparam int PROD_W     = FRAME_HALF + NSEC_W;
  localparam int NUM_W      = FRAME_W + NSEC_W;
  localparam int DIV_STEPS  = NUM_W;
  localparam int DCNT_W     = $clog2(DIV_STEPS + 1);
  localparam int TOT_W      = BNS_W + USED_W;
  localparam int WORD_W     = 2 * SAMPLE_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = BNS_W;

  localparam int CMDQ_DEPTH = 2;
  localparam int OQ_DEPTH   = 2;
  localparam int QPTR_W     = $clog2(CMDQ_DEPTH);
  localparam int QCNT_W     = $clog2(CMDQ_DEPTH + 1);
  localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

  localparam logic [NSEC_W-1:0] NS_PER_SEC = 30'd1000000000;
  // Quotient at or above this means the frame time saturates at all ones.
  localparam logic [NUM_W-1:0]  TIME_SAT   = NUM_W'(64'hFFFF_FFFF_D5B5_1A00);

  localparam logic [RATE_W-1:0] RATE_RST = 19'd48000;
  localparam logic [BNS_W-1:0]  BNS_RST  = 34'd10000000;
  localparam logic [CHC_W-1:0]  CHC_RST  = 4'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_NS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [1:0] FUNC_ADD      = 2'd0;
  localparam logic [1:0] FUNC_HULL     = 2'd1;
  localparam logic [1:0] FUNC_POINT    = 2'd2;
  localparam logic [1:0] FUNC_RESERVED = 2'd3;

  typedef enum logic [2:0] {
    OP_ZERO  = 3'd0,
    OP_EMPTY = 3'd1,
    OP_ADD   = 3'd2,
    OP_HULL  = 3'd3,
    OP_POINT = 3'd4
  } op_t;

  typedef logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] samples_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [BNS_W-1:0]  bns;
    logic [CHC_W-1:0]  chc;
  } cfg_t;

  typedef struct packed {
    op_t                        op;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic signed [TIME_W-1:0]   t_from;
    logic signed [TIME_W-1:0]   t_to;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] env_min;
    logic signed [SAMPLE_W-1:0] env_max;
    logic                       empty_res;
    logic                       dropped;
  } res_t;

endpackage
`default_nettype wire

// File: src/pes_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pes_front
// Accepts requests, reduces the active channels to a min/max pair and
// classifies each request into a command for the back end.
// ----------------------------------------------------------------------------
module pes_front (
  input  logic                     in_push,
  input  logic [1:0]               in_func,
  input  pes_pkg::samples_t        samples,
  input  logic signed [63:0]       in_time_from,
  input  logic signed [63:0]       in_time_to,
  input  pes_pkg::cfg_t            cfg,
  input  logic                     q_full,
  input  logic                     clearing,
  output logic                     in_full,
  output logic                     q_push,
  output pes_pkg::cmd_t            q_cmd
);
  import pes_pkg::*;

  logic [CHC_W-1:0]           ch;
  logic                       cfg_ok;
  logic signed [SAMPLE_W-1:0] lo;
  logic signed [SAMPLE_W-1:0] hi;

  assign ch      = (cfg.chc > CHC_W'(MAX_CHANNELS)) ? CHC_W'(MAX_CHANNELS) : cfg.chc;
  assign cfg_ok  = (cfg.rate != '0) && (cfg.bns != '0);
  assign in_full = q_full | clearing;
  assign q_push  = in_push & ~in_full;

  always_comb begin
    lo = $signed(samples[0]);
    hi = $signed(samples[0]);
    for (int c = 1; c < MAX_CHANNELS; c++) begin
      if (CHC_W'(c) < ch) begin
        if ($signed(samples[c]) < lo) lo = $signed(samples[c]);
        if ($signed(samples[c]) > hi) hi = $signed(samples[c]);
      end
    end
  end

  always_comb begin
    q_cmd.lo     = lo;
    q_cmd.hi     = hi;
    q_cmd.t_from = in_time_from;
    q_cmd.t_to   = in_time_to;
    case (in_func)
      FUNC_ADD: begin
        q_cmd.op = (cfg_ok && (ch != '0)) ? OP_ADD : OP_ZERO;
      end
      FUNC_HULL: begin
        q_cmd.op = cfg_ok ? OP_HULL : OP_EMPTY;
      end
      FUNC_POINT: begin
        q_cmd.op = (cfg_ok && !in_time_from[TIME_W-1]) ? OP_POINT : OP_EMPTY;
      end
      default: begin
        q_cmd.op = OP_ZERO;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: src/pes_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pes_cmd_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pes_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pes_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output pes_pkg::cmd_t rdata,
  output logic          empty
);
  import pes_pkg::*;

  cmd_t              ent_r [CMDQ_DEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = ent_r[rp_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= wdata;
  end

endmodule
`default_nettype wire

// File: src/pes_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pes_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pes_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pes_pkg::NUM_W-1:0]   dividend,
  input  logic [pes_pkg::BNS_W-1:0]   divisor,
  output logic                        done,
  output logic [pes_pkg::NUM_W-1:0]   quotient
);
  import pes_pkg::*;

  logic [BNS_W-1:0]  rem_r;
  logic [BNS_W-1:0]  dvs_r;
  logic [NUM_W-1:0]  quo_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              run_r;
  logic              done_r;
  logic [BNS_W:0]    rs;
  logic [BNS_W:0]    sub;
  logic              ge;

  assign rs       = {rem_r, quo_r[NUM_W-1]};
  assign sub      = rs - {1'b0, dvs_r};
  assign ge       = (rs >= {1'b0, dvs_r});
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (run_r) begin
      rem_r <= ge ? sub[BNS_W-1:0] : rs[BNS_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// File: src/pes_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pes_back
// Executes commands: bucket index computation, bucket read-modify-write,
// hull sweeps and point reads. Holds the bucket memory and result queue.
// ----------------------------------------------------------------------------
module pes_back (
  input  logic          clk,
  input  logic          rst_n,
  input  pes_pkg::cfg_t cfg,
  input  logic          cmd_empty,
  input  pes_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          out_pop,
  output logic          out_empty,
  output pes_pkg::res_t out_res,
  output logic          clearing
);
  import pes_pkg::*;

  typedef enum logic [18:0] {
    ST_CLEAR   = 19'h00001,
    ST_IDLE    = 19'h00002,
    ST_MUL_LO  = 19'h00004,
    ST_MUL_HI  = 19'h00008,
    ST_SUM     = 19'h00010,
    ST_DIV_T   = 19'h00020,
    ST_DIV_IDX = 19'h00040,
    ST_RMW_RD  = 19'h00080,
    ST_RMW_WR  = 19'h00100,
    ST_HULL_A  = 19'h00200,
    ST_HULL_B  = 19'h00400,
    ST_HULL_C  = 19'h00800,
    ST_HDIV_F  = 19'h01000,
    ST_HDIV_L  = 19'h02000,
    ST_SWEEP   = 19'h04000,
    ST_SW_DONE = 19'h08000,
    ST_PDIV    = 19'h10000,
    ST_PRD     = 19'h20000,
    ST_PDONE   = 19'h40000
  } state_t;

  state_t                     state_r, state_nxt;
  cmd_t                       cur_r, cur_nxt;
  logic [FRAME_W-1:0]         fc_r, fc_nxt;
  logic [USED_W-1:0]          used_r, used_nxt;
  logic [ADDR_W-1:0]          idx_r, idx_nxt;
  logic [ADDR_W-1:0]          last_r, last_nxt;
  logic [PROD_W-1:0]          prod_lo_r, prod_lo_nxt;
  logic [PROD_W-1:0]          prod_hi_r, prod_hi_nxt;
  logic [TOT_W-1:0]           total_r, total_nxt;
  logic signed [TIME_W-1:0]   b_r, b_nxt;
  logic signed [TIME_W-1:0]   e_r, e_nxt;
  logic [TOT_W-1:0]           bc_r, bc_nxt;
  logic [TOT_W-1:0]           ec_r, ec_nxt;
  logic signed [SAMPLE_W-1:0] acc_lo_r, acc_lo_nxt;
  logic signed [SAMPLE_W-1:0] acc_hi_r, acc_hi_nxt;
  logic                       take_r, take_nxt;
  logic                       pend_r, pend_nxt;

  logic [WORD_W-1:0]          bucket_mem_r [BUCKET_DEPTH];
  logic [WORD_W-1:0]          rd_data_r;
  logic                       mem_we;
  logic [WORD_W-1:0]          mem_wdata;

  logic                       div_start;
  logic [NUM_W-1:0]           div_dividend;
  logic [BNS_W-1:0]           div_divisor;
  logic                       div_done;
  logic [NUM_W-1:0]           div_q;

  logic                       res_push;
  res_t                       res_data;
  res_t                       oq_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]        oq_wp_r, oq_rp_r;
  logic [OQ_CNT_W-1:0]        oq_cnt_r;
  logic                       oq_full;
  logic                       oq_pop;

  logic signed [SAMPLE_W-1:0] bv_lo, bv_hi;
  logic signed [SAMPLE_W-1:0] cmb_lo, cmb_hi;
  logic signed [SAMPLE_W-1:0] mrg_lo, mrg_hi;
  logic signed [TIME_W-1:0]   tot_s;
  logic signed [TIME_W-1:0]   bcl, ecl;
  logic [TOT_W-1:0]           ec_m1;
  logic [USED_W-1:0]          used_m1;
  logic [USED_W-1:0]          idx_p1;
  logic [TIME_W-1:0]          t_ns;
  logic [FRAME_W-1:0]         fc_inc;

  pes_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign clearing  = (state_r == ST_CLEAR);
  assign oq_full   = (oq_cnt_r == OQ_CNT_W'(OQ_DEPTH));
  assign out_empty = (oq_cnt_r == '0);
  assign out_res   = oq_r[oq_rp_r];
  assign oq_pop    = out_pop & ~out_empty;

  assign bv_lo   = rd_data_r[WORD_W-1] ? $signed(rd_data_r[SAMPLE_W-1:0]) : '0;
  assign bv_hi   = rd_data_r[WORD_W-1] ? $signed(rd_data_r[2*SAMPLE_W-1:SAMPLE_W]) : '0;
  assign cmb_lo  = (take_r || (bv_lo < acc_lo_r)) ? bv_lo : acc_lo_r;
  assign cmb_hi  = (take_r || (bv_hi > acc_hi_r)) ? bv_hi : acc_hi_r;
  assign mrg_lo  = (rd_data_r[WORD_W-1] && (bv_lo < cur_r.lo)) ? bv_lo : cur_r.lo;
  assign mrg_hi  = (rd_data_r[WORD_W-1] && (bv_hi > cur_r.hi)) ? bv_hi : cur_r.hi;
  assign tot_s   = $signed(TIME_W'(total_r));
  assign bcl     = b_r[TIME_W-1] ? '0 : b_r;
  assign ecl     = (e_r > tot_s) ? tot_s : e_r;
  assign ec_m1   = ec_r - 1'b1;
  assign used_m1 = used_r - 1'b1;
  assign idx_p1  = USED_W'(idx_r) + 1'b1;
  assign t_ns    = (div_q >= TIME_SAT) ? '1 : div_q[TIME_W-1:0];
  assign fc_inc  = (fc_r == '1) ? fc_r : fc_r + 1'b1;

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    fc_nxt       = fc_r;
    used_nxt     = used_r;
    idx_nxt      = idx_r;
    last_nxt     = last_r;
    prod_lo_nxt  = prod_lo_r;
    prod_hi_nxt  = prod_hi_r;
    total_nxt    = total_r;
    b_nxt        = b_r;
    e_nxt        = e_r;
    bc_nxt       = bc_r;
    ec_nxt       = ec_r;
    acc_lo_nxt   = acc_lo_r;
    acc_hi_nxt   = acc_hi_r;
    take_nxt     = take_r;
    pend_nxt     = pend_r;
    cmd_pop      = 1'b0;
    mem_we       = 1'b0;
    mem_wdata    = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = cfg.bns;
    res_push     = 1'b0;
    res_data     = '0;

    case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == ADDR_W'(BUCKET_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (!cmd_empty && !oq_full) begin
          cmd_pop = 1'b1;
          cur_nxt = cmd;
          case (cmd.op)
            OP_ADD: begin
              state_nxt = ST_MUL_LO;
            end
            OP_HULL: begin
              if (used_r == '0) begin
                res_push           = 1'b1;
                res_data.empty_res = 1'b1;
              end else begin
                state_nxt = ST_HULL_A;
              end
            end
            OP_POINT: begin
              if (used_r == '0) begin
                res_push           = 1'b1;
                res_data.empty_res = 1'b1;
              end else begin
                div_start    = 1'b1;
                div_dividend = NUM_W'($unsigned(cmd.t_from));
                state_nxt    = ST_PDIV;
              end
            end
            OP_EMPTY: begin
              res_push           = 1'b1;
              res_data.empty_res = 1'b1;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      ST_MUL_LO: begin
        prod_lo_nxt = PROD_W'(fc_r[FRAME_HALF-1:0]) * PROD_W'(NS_PER_SEC);
        state_nxt   = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        prod_hi_nxt = PROD_W'(fc_r[FRAME_W-1:FRAME_HALF]) * PROD_W'(NS_PER_SEC);
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        div_start    = 1'b1;
        div_dividend = NUM_W'(prod_lo_r) + (NUM_W'(prod_hi_r) << FRAME_HALF);
        div_divisor  = BNS_W'(cfg.rate);
        state_nxt    = ST_DIV_T;
      end
      ST_DIV_T: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = NUM_W'(t_ns);
          state_nxt    = ST_DIV_IDX;
        end
      end
      ST_DIV_IDX: begin
        if (div_done) begin
          if (div_q >= NUM_W'(BUCKET_DEPTH)) begin
            res_push         = 1'b1;
            res_data.dropped = 1'b1;
            fc_nxt           = fc_inc;
            state_nxt        = ST_IDLE;
          end else begin
            idx_nxt   = div_q[ADDR_W-1:0];
            state_nxt = ST_RMW_RD;
          end
        end
      end
      ST_RMW_RD: begin
        state_nxt = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, mrg_hi, mrg_lo};
        if (idx_p1 > used_r) used_nxt = idx_p1;
        fc_nxt    = fc_inc;
        res_push  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_HULL_A: begin
        if (cur_r.t_to < cur_r.t_from) begin
          b_nxt = cur_r.t_to;
          e_nxt = cur_r.t_from;
        end else begin
          b_nxt = cur_r.t_from;
          e_nxt = cur_r.t_to;
        end
        total_nxt = TOT_W'(cfg.bns) * TOT_W'(used_r);
        state_nxt = ST_HULL_B;
      end
      ST_HULL_B: begin
        if (e_r[TIME_W-1] || (bcl >= tot_s)) begin
          res_push           = 1'b1;
          res_data.empty_res = 1'b1;
          state_nxt          = ST_IDLE;
        end else begin
          bc_nxt    = bcl[TOT_W-1:0];
          ec_nxt    = ecl[TOT_W-1:0];
          state_nxt = ST_HULL_C;
        end
      end
      ST_HULL_C: begin
        div_start    = 1'b1;
        div_dividend = NUM_W'(bc_r);
        state_nxt    = ST_HDIV_F;
      end
      ST_HDIV_F: begin
        if (div_done) begin
          idx_nxt = div_q[ADDR_W-1:0];
          if (ec_r > bc_r) begin
            div_start    = 1'b1;
            div_dividend = NUM_W'(ec_m1);
            state_nxt    = ST_HDIV_L;
          end else begin
            last_nxt  = div_q[ADDR_W-1:0];
            take_nxt  = 1'b1;
            pend_nxt  = 1'b0;
            state_nxt = ST_SWEEP;
          end
        end
      end
      ST_HDIV_L: begin
        if (div_done) begin
          last_nxt  = (div_q >= NUM_W'(used_r)) ? used_m1[ADDR_W-1:0] : div_q[ADDR_W-1:0];
          take_nxt  = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        pend_nxt = 1'b1;
        if (pend_r) begin
          acc_lo_nxt = cmb_lo;
          acc_hi_nxt = cmb_hi;
          take_nxt   = 1'b0;
        end
        if (idx_r == last_r) state_nxt = ST_SW_DONE;
        else idx_nxt = idx_r + 1'b1;
      end
      ST_SW_DONE: begin
        res_push         = 1'b1;
        res_data.env_min = cmb_lo;
        res_data.env_max = cmb_hi;
        state_nxt        = ST_IDLE;
      end
      ST_PDIV: begin
        if (div_done) begin
          if (div_q >= NUM_W'(used_r)) begin
            res_push           = 1'b1;
            res_data.empty_res = 1'b1;
            state_nxt          = ST_IDLE;
          end else begin
            idx_nxt   = div_q[ADDR_W-1:0];
            state_nxt = ST_PRD;
          end
        end
      end
      ST_PRD: begin
        state_nxt = ST_PDONE;
      end
      ST_PDONE: begin
        res_push         = 1'b1;
        res_data.env_min = bv_lo;
        res_data.env_max = bv_hi;
        state_nxt        = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      idx_r    <= '0;
      fc_r     <= '0;
      used_r   <= '0;
      take_r   <= 1'b0;
      pend_r   <= 1'b0;
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      fc_r     <= fc_nxt;
      used_r   <= used_nxt;
      take_r   <= take_nxt;
      pend_r   <= pend_nxt;
      if (res_push) oq_wp_r <= oq_wp_r + 1'b1;
      if (oq_pop) oq_rp_r <= oq_rp_r + 1'b1;
      if (res_push && !oq_pop) oq_cnt_r <= oq_cnt_r + 1'b1;
      if (!res_push && oq_pop) oq_cnt_r <= oq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    last_r    <= last_nxt;
    prod_lo_r <= prod_lo_nxt;
    prod_hi_r <= prod_hi_nxt;
    total_r   <= total_nxt;
    b_r       <= b_nxt;
    e_r       <= e_nxt;
    bc_r      <= bc_nxt;
    ec_r      <= ec_nxt;
    acc_lo_r  <= acc_lo_nxt;
    acc_hi_r  <= acc_hi_nxt;
    if (res_push) oq_r[oq_wp_r] <= res_data;
  end

  // bucket word: {filled, high, low}
  always_ff @(posedge clk) begin
    if (mem_we) bucket_mem_r[idx_r] <= mem_wdata;
    rd_data_r <= bucket_mem_r[idx_r];
  end

endmodule
`default_nettype wire

// File: src/peak_envelope_store_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// peak_envelope_store_top
// Min/max peak envelope store for a multichannel sample stream.
//
//   channel  ports                          handshake
//   input    in_func, in_sample_*, in_time_* push / full
//   result   out_env_*, out_empty_res, ...  empty / pop
//   config   cfg_index, cfg_wdata           cfg_wr_en, no wait
//
// Add frame: two passes of the shared 70-step radix-2 divider (frame
// time, then bucket index) plus the bucket RMW. Hull: one or two divider
// passes plus a sweep of one covered bucket per cycle. Point: one pass
// plus the bucket read. Other requests are answered straight from idle.
// After reset a clearing pass over all 4096 buckets runs with full held high.
// A stalled result side fills a 2-entry result queue and then the
// 2-entry command queue before full rises.
// ----------------------------------------------------------------------------
module peak_envelope_store_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [1:0]           in_func,
  input  logic signed [15:0]   in_sample_0,
  input  logic signed [15:0]   in_sample_1,
  input  logic signed [15:0]   in_sample_2,
  input  logic signed [15:0]   in_sample_3,
  input  logic signed [15:0]   in_sample_4,
  input  logic signed [15:0]   in_sample_5,
  input  logic signed [15:0]   in_sample_6,
  input  logic signed [15:0]   in_sample_7,
  input  logic signed [63:0]   in_time_from,
  input  logic signed [63:0]   in_time_to,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic signed [15:0]   out_env_min,
  output logic signed [15:0]   out_env_max,
  output logic                 out_empty_res,
  output logic                 out_dropped,
  input  logic                 cfg_wr_en,
  input  logic [pes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pes_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pes_pkg::*;

  logic [RATE_W-1:0] rate_r;
  logic [BNS_W-1:0]  bns_r;
  logic [CHC_W-1:0]  chc_r;
  cfg_t              cfg;
  samples_t          samples;
  logic              q_full, q_push, q_pop, q_empty;
  cmd_t              q_wcmd, q_rcmd;
  logic              clearing;
  res_t              res;

  assign cfg.rate = rate_r;
  assign cfg.bns  = bns_r;
  assign cfg.chc  = chc_r;

  assign samples[0] = in_sample_0;
  assign samples[1] = in_sample_1;
  assign samples[2] = in_sample_2;
  assign samples[3] = in_sample_3;
  assign samples[4] = in_sample_4;
  assign samples[5] = in_sample_5;
  assign samples[6] = in_sample_6;
  assign samples[7] = in_sample_7;

  assign out_env_min   = res.env_min;
  assign out_env_max   = res.env_max;
  assign out_empty_res = res.empty_res;
  assign out_dropped   = res.dropped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RST;
      bns_r  <= BNS_RST;
      chc_r  <= CHC_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SAMPLE_RATE: begin
          rate_r <= cfg_wdata[RATE_W-1:0];
        end
        REG_BUCKET_NS: begin
          bns_r <= cfg_wdata[BNS_W-1:0];
        end
        REG_CHANNEL_COUNT: begin
          chc_r <= cfg_wdata[CHC_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  pes_front u_front (
    .in_push      (in_push),
    .in_func      (in_func),
    .samples      (samples),
    .in_time_from (in_time_from),
    .in_time_to   (in_time_to),
    .cfg          (cfg),
    .q_full       (q_full),
    .clearing     (clearing),
    .in_full      (in_full),
    .q_push       (q_push),
    .q_cmd        (q_wcmd)
  );

  pes_cmd_queue u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wcmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rcmd),
    .empty (q_empty)
  );

  pes_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_empty (q_empty),
    .cmd       (q_rcmd),
    .cmd_pop   (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (res),
    .clearing  (clearing)
  );

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the peak envelope store.
//
// Frames and hull/point queries are pushed through the input queue port.
// A behavioral envelope model predicts every result, and each popped
// result is compared field by field. Configuration changes happen only
// while the block is drained. Directed cases are followed by random
// phases under several rate/bucket/channel settings.
// ----------------------------------------------------------------------------
module tb;
  import pes_pkg::*;

  typedef struct {
    logic [1:0]         func;
    samples_t           smp;
    logic signed [63:0] t_from;
    logic signed [63:0] t_to;
  } env_req_t;

  localparam longint unsigned FRAME_LIMIT = (64'd1 << FRAME_W) - 1;
  localparam longint unsigned NSEC        = 64'd1000000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [1:0] in_func = '0;
  logic signed [15:0] in_sample_0 = '0, in_sample_1 = '0, in_sample_2 = '0,
    in_sample_3 = '0, in_sample_4 = '0, in_sample_5 = '0, in_sample_6 = '0,
    in_sample_7 = '0;
  logic signed [63:0] in_time_from = '0, in_time_to = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [15:0] out_env_min, out_env_max;
  logic out_empty_res, out_dropped;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // envelope model state
  logic [RATE_W-1:0]  mdl_rate;
  logic [BNS_W-1:0]   mdl_bns;
  logic [CHC_W-1:0]   mdl_chc;
  logic signed [15:0] env_lo [BUCKET_DEPTH];
  logic signed [15:0] env_hi [BUCKET_DEPTH];
  bit                 env_set [BUCKET_DEPTH];
  longint unsigned    frames_seen;
  int unsigned        used_buckets;

  res_t env_pending[$];
  int   errors = 0;
  int   n_add = 0, n_hull = 0, n_point = 0, n_drop = 0, n_empty = 0;
  int   burst_left = 0;
  int   phase_pattern = 0;

  always #10 clk = ~clk;

  peak_envelope_store_top i_dut (
    .clk, .rst_n, .in_push, .in_full, .in_func,
    .in_sample_0, .in_sample_1, .in_sample_2, .in_sample_3,
    .in_sample_4, .in_sample_5, .in_sample_6, .in_sample_7,
    .in_time_from, .in_time_to, .out_empty, .out_pop,
    .out_env_min, .out_env_max, .out_empty_res, .out_dropped,
    .cfg_wr_en, .cfg_index, .cfg_wdata
  );

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint unsigned frame_bucket(input longint unsigned f);
    longint unsigned whole, rem, t;
    whole = f / mdl_rate;
    rem = f % mdl_rate;
    if (whole > (64'hFFFF_FFFF_FFFF_FFFF - NSEC) / NSEC)
      t = 64'hFFFF_FFFF_FFFF_FFFF;
    else
      t = whole * NSEC + (rem * NSEC) / mdl_rate;
    return t / mdl_bns;
  endfunction

  task automatic read_env(input int unsigned i, output logic signed [15:0] lo,
                          output logic signed [15:0] hi);
    lo = env_set[i] ? env_lo[i] : 16'sd0;
    hi = env_set[i] ? env_hi[i] : 16'sd0;
  endtask

  task automatic predict_envelope(input env_req_t r, output res_t e);
    int ch;
    bit valid;
    logic signed [15:0] lo, hi, blo, bhi;
    longint unsigned idx;
    longint signed width, total, b, e2, tmp;
    int unsigned first, last;
    e = '0;
    valid = (mdl_rate != 0) && (mdl_bns != 0);
    case (r.func)
      FUNC_ADD: begin
        ch = (mdl_chc > MAX_CHANNELS) ? MAX_CHANNELS : int'(mdl_chc);
        if (valid && ch != 0) begin
          lo = r.smp[0];
          hi = r.smp[0];
          for (int c = 1; c < ch; c++) begin
            if ($signed(r.smp[c]) < lo) lo = r.smp[c];
            if ($signed(r.smp[c]) > hi) hi = r.smp[c];
          end
          idx = frame_bucket(frames_seen);
          if (idx >= BUCKET_DEPTH) begin
            e.dropped = 1'b1;
          end else begin
            if (env_set[idx]) begin
              if (lo < env_lo[idx]) env_lo[idx] = lo;
              if (hi > env_hi[idx]) env_hi[idx] = hi;
            end else begin
              env_lo[idx] = lo;
              env_hi[idx] = hi;
              env_set[idx] = 1'b1;
            end
            if (idx + 1 > used_buckets) used_buckets = 32'(idx + 1);
          end
          if (frames_seen < FRAME_LIMIT) frames_seen++;
        end
      end
      FUNC_HULL: begin
        if (!valid || used_buckets == 0) begin
          e.empty_res = 1'b1;
        end else begin
          width = longint'(mdl_bns);
          total = width * longint'(used_buckets);
          b = r.t_from;
          e2 = r.t_to;
          if (e2 < b) begin
            tmp = b; b = e2; e2 = tmp;
          end
          if (e2 < 0) begin
            e.empty_res = 1'b1;
          end else begin
            if (b < 0) b = 0;
            if (b >= total) begin
              e.empty_res = 1'b1;
            end else begin
              if (e2 > total) e2 = total;
              first = 32'(b / width);
              last = (e2 > b) ? 32'((e2 - 1) / width) : first;
              if (last > used_buckets - 1) last = used_buckets - 1;
              read_env(first, lo, hi);
              for (int unsigned i = first + 1; i <= last; i++) begin
                read_env(i, blo, bhi);
                if (blo < lo) lo = blo;
                if (bhi > hi) hi = bhi;
              end
              e.env_min = lo;
              e.env_max = hi;
            end
          end
        end
      end
      FUNC_POINT: begin
        if (!valid || used_buckets == 0 || r.t_from < 0) begin
          e.empty_res = 1'b1;
        end else begin
          idx = longint'(r.t_from) / longint'(mdl_bns);
          if (idx >= used_buckets) begin
            e.empty_res = 1'b1;
          end else begin
            read_env(32'(idx), lo, hi);
            e.env_min = lo;
            e.env_max = hi;
          end
        end
      end
      default: ;
    endcase
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic send_request(input env_req_t r);
    res_t e;
    if (burst_left == 0) begin
      in_push = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_func = r.func;
    {in_sample_7, in_sample_6, in_sample_5, in_sample_4,
     in_sample_3, in_sample_2, in_sample_1, in_sample_0} = r.smp;
    in_time_from = r.t_from;
    in_time_to = r.t_to;
    in_push = 1'b1;
    do @(posedge clk); while (in_full);
    predict_envelope(r, e);
    env_pending.push_back(e);
    case (r.func)
      FUNC_ADD:   n_add++;
      FUNC_HULL:  n_hull++;
      FUNC_POINT: n_point++;
      default: ;
    endcase
    @(negedge clk);
    in_push = 1'b0;
  endtask

  // result side: out_pop follows a randomly drawn stall pattern
  always @(negedge clk) begin
    if (($time / 20) % 64 == 0) phase_pattern = $urandom_range(0, 3);
    case (phase_pattern)
      0: out_pop = 1'b1;
      1: out_pop = ($urandom_range(0, 3) != 0);
      2: out_pop = ($urandom_range(0, 3) == 0);
      default: out_pop = ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (env_pending.size() == 0) begin
        report("result with no request pending");
      end else begin
        e = env_pending.pop_front();
        if (out_env_min !== e.env_min)
          report($sformatf("env_min %0d exp %0d", out_env_min, e.env_min));
        if (out_env_max !== e.env_max)
          report($sformatf("env_max %0d exp %0d", out_env_max, e.env_max));
        if (out_empty_res !== e.empty_res)
          report($sformatf("empty_res %b exp %b", out_empty_res, e.empty_res));
        if (out_dropped !== e.dropped)
          report($sformatf("dropped %b exp %b", out_dropped, e.dropped));
        if (e.dropped) n_drop++;
        if (e.empty_res) n_empty++;
      end
    end
  end

  task automatic drain();
    while (env_pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_index = idx;
    cfg_wdata = val;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      REG_SAMPLE_RATE:   mdl_rate = val[RATE_W-1:0];
      REG_BUCKET_NS:     mdl_bns = val;
      REG_CHANNEL_COUNT: mdl_chc = val[CHC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input longint unsigned rate, input longint unsigned bns,
                            input int unsigned chc);
    drain();
    write_reg(REG_SAMPLE_RATE, CFG_DATA_W'(rate));
    write_reg(REG_BUCKET_NS, CFG_DATA_W'(bns));
    write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(chc));
  endtask

  function automatic env_req_t make_req(input logic [1:0] f, input longint tf,
                                        input longint tt);
    env_req_t r;
    r.func = f;
    for (int c = 0; c < MAX_CHANNELS; c++) r.smp[c] = SAMPLE_W'($urandom);
    r.t_from = tf;
    r.t_to = tt;
    return r;
  endfunction

  function automatic longint rand_time();
    longint span;
    span = longint'(mdl_bns) * longint'((used_buckets == 0) ? 4 : used_buckets);
    if (span <= 0) span = 1000;
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return -longint'($urandom_range(1, 1000));
      2: return span + $urandom_range(0, 1000);
      default: return longint'(({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF)
                               % longint'(span + span / 8 + 1));
    endcase
  endfunction

  function automatic env_req_t random_req();
    int k;
    longint tf, tt;
    k = $urandom_range(0, 99);
    tf = rand_time();
    tt = rand_time();
    // keep most hulls short so run time stays bounded
    if (k >= 70 && k < 90 && $urandom_range(0, 3) != 0)
      tt = tf + longint'(mdl_bns) * $urandom_range(0, 16);
    if (k < 70) return make_req(FUNC_ADD, tf, tt);
    if (k < 90) return make_req(FUNC_HULL, tf, tt);
    if (k < 98) return make_req(FUNC_POINT, tf, tt);
    return make_req(FUNC_RESERVED, tf, tt);
  endfunction

  task automatic test_directed();
    env_req_t r;
    // queries on an empty store
    send_request(make_req(FUNC_HULL, 0, 64'sd1000000000));
    send_request(make_req(FUNC_POINT, 0, 0));
    send_request(make_req(FUNC_RESERVED, -1, -1));
    r = make_req(FUNC_ADD, 0, 0);
    r.smp = '0;
    r.smp[0] = 16'sh7FFF;
    r.smp[1] = 16'sh8000;
    send_request(r);
    r.smp[0] = 16'sh8000;
    r.smp[1] = 16'sh8000;
    send_request(r);
    for (int i = 0; i < 6; i++) send_request(make_req(FUNC_ADD, 0, 0));
    send_request(make_req(FUNC_HULL, 64'sd20000000, 0));
    send_request(make_req(FUNC_HULL, 5, 5));
    send_request(make_req(FUNC_HULL, -100, -1));
    send_request(make_req(FUNC_HULL, -100, 64'sh7FFF_FFFF_FFFF_FFFF));
    send_request(make_req(FUNC_HULL, 64'sd10000000, 64'sd10000000));
    send_request(make_req(FUNC_HULL, 64'sh8000_0000_0000_0000, 64'sd1));
    send_request(make_req(FUNC_POINT, -1, 0));
    send_request(make_req(FUNC_POINT, 64'sd10000000, 0));
    send_request(make_req(FUNC_POINT, 64'sh7FFF_FFFF_FFFF_FFFF, 0));
  endtask

  task automatic test_config_edges();
    // invalid block: adds inert, queries empty
    set_config(0, 10000000, 2);
    send_request(make_req(FUNC_ADD, 0, 0));
    send_request(make_req(FUNC_HULL, 0, 100));
    send_request(make_req(FUNC_POINT, 0, 0));
    set_config(48000, 0, 2);
    send_request(make_req(FUNC_ADD, 0, 0));
    send_request(make_req(FUNC_POINT, 0, 0));
    // zero channels, then saturating channel count
    set_config(48000, 10000000, 0);
    send_request(make_req(FUNC_ADD, 0, 0));
    set_config(48000, 10000000, 15);
    repeat (4) send_request(make_req(FUNC_ADD, 0, 0));
    set_config(384000, 34'h3_FFFF_FFFF, 1);
    repeat (3) send_request(make_req(FUNC_ADD, 0, 0));
    send_request(make_req(FUNC_HULL, 0, 64'sh7FFF_FFFF_FFFF_FFFF));
    // one frame per second, 1 ns buckets: every frame lands past the store
    set_config(1, 1, 8);
    repeat (4) send_request(make_req(FUNC_ADD, 0, 0));
    send_request(make_req(FUNC_POINT, 0, 0));
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_request(random_req());
  endtask

  initial begin
    mdl_rate = RATE_RST;
    mdl_bns = BNS_RST;
    mdl_chc = CHC_RST;
    frames_seen = 0;
    used_buckets = 0;
    for (int i = 0; i < BUCKET_DEPTH; i++) env_set[i] = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_config_edges();
    set_config(48000, 20833, 8);
    test_random(250);
    set_config(44100, 50000, 3);
    test_random(200);
    set_config(384000, 2600, $urandom_range(1, 8));
    test_random(200);
    set_config(8000, 64'd10000000000, 2);
    test_random(100);
    drain();
    $display("Covered %0d adds, %0d hulls, %0d points; %0d drops, %0d empty answers.",
             n_add, n_hull, n_point, n_drop, n_empty);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #200ms;
    $display("Timeout with %0d results outstanding", env_pending.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
